// File: rtl/core/hlcd_pkg.sv
// Shared types and constants for the header/length/checksum frame parser.
package hlcd_pkg;

  // Header byte value that the block uses after reset.
  localparam logic [7:0] HEADER_RESET = 8'h68;

  // The first payload word is flagged as in range when it is below this value.
  localparam logic [15:0] WORD_LIMIT = 16'd4095;

  // One parsed frame, as handed to the result channel.
  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  target_code;
    logic [7:0]  payload_length;
    logic [15:0] first_word;
    logic        word_in_range;
    logic        checksum_ok;
  } frame_result_t;

endpackage

// File: rtl/core/hlcd_if.sv
// Handshake interfaces for the byte, configuration and frame result channels.
interface hlcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_header;

  modport source (output valid, output frame_header, input ready);
  modport sink (input valid, input frame_header, output ready);
endinterface

interface hlcd_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [7:0]  target_code;
  logic [7:0]  payload_length;
  logic [15:0] first_word;
  logic        word_in_range;
  logic        checksum_ok;

  modport source (
    output valid, output command_code, output target_code, output payload_length,
    output first_word, output word_in_range, output checksum_ok, input ready
  );
  modport sink (
    input valid, input command_code, input target_code, input payload_length,
    input first_word, input word_in_range, input checksum_ok, output ready
  );
endinterface

// File: rtl/core/header_length_checksum_deframer.sv
// Top level of the header/length/checksum frame parser.
//
// Received bytes arrive on the rx channel, one byte per transfer. The block
// hunts for the header byte, then takes a command byte, a target byte, a
// length byte, that many payload bytes and a checksum byte. When the checksum
// byte has been parsed, one transfer on the frame channel carries the command,
// target, length, the first payload word, its range flag and the checksum flag.
// The cfg channel writes the header byte; it is always ready and should only
// be used while no frame is in flight.
// Each accepted byte goes through an input register and is parsed while it
// sits there, once the result register can take a result; the checksum
// byte's result is written to the result register, which drives frame.valid.
// One byte is taken every cycle, limited only by the single-entry input and
// result registers.
// Reset clears the parser to hunting, empties both registers and restores the
// header byte to 0x68. When the receiver stalls, a pending result holds, the
// next byte waits in the input register, and rx.ready drops only once both
// registers are full.
module header_length_checksum_deframer (
  input  logic                 clk,
  input  logic                 rst,
  hlcd_rx_if.sink              rx,
  hlcd_cfg_if.sink             cfg,
  hlcd_frame_if.source         frame
);

  // Header byte register, written from the configuration channel.
  logic [7:0] frame_header;

  // Input register stage.
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register stage.
  logic                    out_valid, out_valid_next;
  hlcd_pkg::frame_result_t out_data;

  // Parser outputs for the byte held in the input register.
  logic                    res_valid;
  hlcd_pkg::frame_result_t res_data;

  // The input register moves on when the result register is empty or is
  // being emptied this cycle.
  logic advance;

  assign advance  = !out_valid || frame.ready;
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= hlcd_pkg::HEADER_RESET;
    end else if (cfg.valid) begin
      frame_header <= cfg.frame_header;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  hlcd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (in_valid && advance),
    .rx_byte      (in_byte),
    .frame_header (frame_header),
    .result_valid (res_valid),
    .result       (res_data)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = in_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res_valid) begin
      out_data <= res_data;
    end
  end

  assign frame.valid          = out_valid;
  assign frame.command_code   = out_data.command_code;
  assign frame.target_code    = out_data.target_code;
  assign frame.payload_length = out_data.payload_length;
  assign frame.first_word     = out_data.first_word;
  assign frame.word_in_range  = out_data.word_in_range;
  assign frame.checksum_ok    = out_data.checksum_ok;

  // With the result register empty, the block must always take a byte.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> rx.ready)
    else $error("rx not ready while result register is empty");

  // A result can only come from a byte that sits in the input register.
  assert property (@(posedge clk) disable iff (rst) res_valid && advance |-> in_valid)
    else $error("parser produced a result without an input byte");

  // A byte held back by a stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled input byte was lost or changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

// File: rtl/core/hlcd_parser.sv
// Frame parsing state machine: phase, running sum and held frame fields.
module hlcd_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  input  logic [7:0]                 rx_byte,
  input  logic [7:0]                 frame_header,
  output logic                       result_valid,
  output hlcd_pkg::frame_result_t    result
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_TGT  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_target, held_target_next;
  logic [7:0]  held_length, held_length_next;
  logic [15:0] held_word, held_word_next;
  logic [7:0]  sum_plus_byte;
  logic [7:0]  count_plus_one;

  assign sum_plus_byte  = running_sum + rx_byte;
  assign count_plus_one = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    payload_count_next = payload_count;
    held_command_next  = held_command;
    held_target_next   = held_target;
    held_length_next   = held_length;
    held_word_next     = held_word;
    result_valid       = 1'b0;

    result.command_code   = held_command;
    result.target_code    = held_target;
    result.payload_length = held_length;
    result.first_word     = held_word;
    result.word_in_range  = (held_word < hlcd_pkg::WORD_LIMIT);
    result.checksum_ok    = (running_sum == rx_byte);

    if (byte_valid) begin
      unique case (phase)
        PH_CMD: begin
          held_command_next = rx_byte;
          running_sum_next  = sum_plus_byte;
          phase_next        = PH_TGT;
        end
        PH_TGT: begin
          held_target_next = rx_byte;
          running_sum_next = sum_plus_byte;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          held_length_next   = rx_byte;
          running_sum_next   = sum_plus_byte;
          payload_count_next = 8'd0;
          held_word_next     = 16'd0;
          phase_next         = (rx_byte == 8'd0) ? PH_CHK : PH_PAY;
        end
        PH_PAY: begin
          running_sum_next = sum_plus_byte;
          if (payload_count == 8'd0) begin
            held_word_next = {rx_byte, 8'd0};
          end else if (payload_count == 8'd1) begin
            held_word_next = {held_word[15:8], rx_byte};
          end
          payload_count_next = count_plus_one;
          if (count_plus_one == held_length) begin
            phase_next = PH_CHK;
          end
        end
        PH_CHK: begin
          result_valid     = 1'b1;
          running_sum_next = 8'd0;
          phase_next       = PH_HUNT;
        end
        default: begin
          // Hunting, and the two unused phase codes behave the same way.
          if (rx_byte == frame_header) begin
            running_sum_next = rx_byte;
            phase_next       = PH_CMD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= 8'd0;
      payload_count <= 8'd0;
      held_command  <= 8'd0;
      held_target   <= 8'd0;
      held_length   <= 8'd0;
      held_word     <= 16'd0;
    end else begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      payload_count <= payload_count_next;
      held_command  <= held_command_next;
      held_target   <= held_target_next;
      held_length   <= held_length_next;
      held_word     <= held_word_next;
    end
  end

endmodule
